// File: hdl/dq_pkg.sv
// shared types and constants for the byte deque
package dq_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int KIND_W   = 3;
    localparam int DATA_W   = 8;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_READ       = 3'd4,
        KIND_COUNT      = 3'd5
    } kind_t;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD   = 2'd3;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LOAD = 1'b1
    } fsm_t;

endpackage

// File: hdl/dq_ram.sv
// single-port byte ring store with registered read data
module dq_ram #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic                      we,
    input  logic [AW-1:0]             addr,
    input  logic [dq_pkg::DATA_W-1:0] wdata,
    output logic [dq_pkg::DATA_W-1:0] rdata
);

    logic [dq_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// File: hdl/byte_deque_with_index_read.sv
// top level of the byte deque with indexed read
//
// Bounded double-ended queue of DEPTH bytes held in a single-port ring memory with a front
// pointer and a fill count. Each request beat on the s_ side (kind in s_tuser) pushes at the
// front or back, pops from the front or back, reads the byte at a position from the front,
// or only reports the count; every request gives exactly one result beat on the m_ side with
// the byte, a status (ok, empty or miss, full push dropped) and the count after the request.
// A request is handled in S_IDLE and S_LOAD: the accept cycle in S_IDLE does the memory access and
// pointer update, and S_LOAD moves the registered memory read data into the result register.
// s_tready is low in S_LOAD, which holds while a finished result cannot yet move into an
// occupied result register; one request may be accepted while an earlier result waits to be
// taken, and the next one only after S_LOAD is left. Kind codes 6 and 7 act as count only.
module byte_deque_with_index_read #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dq_pkg::S_TDATA_W-1:0] s_tdata,   // data_in[7:0], position[13:8]
    input  logic [dq_pkg::KIND_W-1:0]    s_tuser,   // kind[2:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dq_pkg::M_TDATA_W-1:0] m_tdata,   // data_out[7:0], occupancy[14:8]
    output logic [dq_pkg::STATUS_W-1:0]  m_tuser    // status[1:0]
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = (CW > dq_pkg::POS_W) ? CW : dq_pkg::POS_W;
    localparam int SW = OW + 1;

    localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_SUM  = SW'(DEPTH);

    dq_pkg::fsm_t state_reg, state_next;

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;

    logic [dq_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [dq_pkg::OCC_W-1:0]    res_occ_reg, res_occ_next;
    logic                        res_rd_reg, res_rd_next;

    logic                        m_valid_reg, m_valid_next;
    logic [dq_pkg::DATA_W-1:0]   m_data_reg, m_data_next;
    logic [dq_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [dq_pkg::OCC_W-1:0]    m_occ_reg, m_occ_next;

    logic                        s_accept;
    logic                        out_free;
    logic                        load_out;
    dq_pkg::kind_t               kind;
    logic [dq_pkg::DATA_W-1:0]   data_in;
    logic [dq_pkg::POS_W-1:0]    position;

    logic [OW-1:0]               offset;
    logic [SW-1:0]               slot_sum;
    logic [AW-1:0]               slot;
    logic                        is_full;
    logic                        is_empty;
    logic                        mem_en;
    logic                        mem_we;
    logic [AW-1:0]               mem_addr;
    logic [dq_pkg::DATA_W-1:0]   mem_rdata;

    assign kind     = dq_pkg::kind_t'(s_tuser);
    assign data_in  = s_tdata[dq_pkg::DATA_W-1:0];
    assign position = s_tdata[dq_pkg::DATA_W +: dq_pkg::POS_W];

    assign out_free = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign is_full  = (count_reg == FULL_COUNT);
    assign is_empty = (count_reg == '0);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dq_pkg::S_IDLE: begin
                if (s_tvalid) state_next = dq_pkg::S_LOAD;
            end
            dq_pkg::S_LOAD: begin
                if (out_free) state_next = dq_pkg::S_IDLE;
            end
            default: state_next = dq_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            dq_pkg::S_IDLE: s_tready = 1'b1;
            dq_pkg::S_LOAD: load_out = out_free;
            default: begin
                s_tready = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // slot of an offset from the front, wrapped once
    always_comb begin
        case (kind)
            dq_pkg::KIND_PUSH_BACK: offset = OW'(count_reg);
            dq_pkg::KIND_POP_BACK:  offset = OW'(count_reg - CW'(1));
            dq_pkg::KIND_READ:      offset = OW'(position);
            default:                offset = '0;
        endcase
        slot_sum = SW'(front_reg) + SW'(offset);
        if (slot_sum >= DEPTH_SUM) slot_sum = slot_sum - DEPTH_SUM;
        slot = slot_sum[AW-1:0];
    end

    // request decode
    always_comb begin
        front_next      = front_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_occ_next    = res_occ_reg;
        res_rd_next     = res_rd_reg;
        mem_en          = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = slot;
        if (s_accept) begin
            res_status_next = dq_pkg::STAT_OK;
            res_rd_next     = 1'b0;
            case (kind)
                dq_pkg::KIND_PUSH_FRONT: begin
                    if (is_full) begin
                        res_status_next = dq_pkg::STAT_FULL;
                    end else begin
                        front_next = (front_reg == '0) ? LAST_SLOT : front_reg - AW'(1);
                        count_next = count_reg + CW'(1);
                        mem_en     = 1'b1;
                        mem_we     = 1'b1;
                        mem_addr   = front_next;
                    end
                end
                dq_pkg::KIND_PUSH_BACK: begin
                    if (is_full) begin
                        res_status_next = dq_pkg::STAT_FULL;
                    end else begin
                        count_next = count_reg + CW'(1);
                        mem_en     = 1'b1;
                        mem_we     = 1'b1;
                    end
                end
                dq_pkg::KIND_POP_FRONT: begin
                    if (is_empty) begin
                        res_status_next = dq_pkg::STAT_EMPTY;
                    end else begin
                        front_next  = (front_reg == LAST_SLOT) ? '0 : front_reg + AW'(1);
                        count_next  = count_reg - CW'(1);
                        mem_en      = 1'b1;
                        mem_addr    = front_reg;
                        res_rd_next = 1'b1;
                    end
                end
                dq_pkg::KIND_POP_BACK: begin
                    if (is_empty) begin
                        res_status_next = dq_pkg::STAT_EMPTY;
                    end else begin
                        count_next  = count_reg - CW'(1);
                        mem_en      = 1'b1;
                        res_rd_next = 1'b1;
                    end
                end
                dq_pkg::KIND_READ: begin
                    if (OW'(position) >= OW'(count_reg)) begin
                        res_status_next = dq_pkg::STAT_EMPTY;
                    end else begin
                        mem_en      = 1'b1;
                        res_rd_next = 1'b1;
                    end
                end
                default: begin
                    res_status_next = dq_pkg::STAT_OK;
                end
            endcase
            res_occ_next = dq_pkg::OCC_W'(count_next);
        end
    end

    // result register
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_occ_next    = m_occ_reg;
        if (m_valid_reg && m_tready) m_valid_next = 1'b0;
        if (load_out) begin
            m_valid_next  = 1'b1;
            m_data_next   = res_rd_reg ? mem_rdata : '0;
            m_status_next = res_status_reg;
            m_occ_next    = res_occ_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dq_pkg::S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_occ_reg    <= res_occ_next;
        res_rd_reg     <= res_rd_next;
        m_data_reg     <= m_data_next;
        m_status_reg   <= m_status_next;
        m_occ_reg      <= m_occ_next;
    end

    dq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (data_in),
        .rdata (mem_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_occ_reg, m_data_reg};
    assign m_tuser  = m_status_reg;

endmodule

// File: hdl/dq_checker.sv
// port-level checker for the byte deque, bound to the top level
module dq_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [dq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [dq_pkg::STATUS_W-1:0]  m_tuser
);

    logic [1:0] owed_reg, owed_next;
    logic       s_beat;
    logic       m_beat;

    assign s_beat = s_tvalid && s_tready;
    assign m_beat = m_tvalid && m_tready;

    // requests accepted whose result beat has not gone out yet
    always_comb begin
        owed_next = owed_reg;
        if (s_beat && !m_beat) owed_next = owed_reg + 2'd1;
        if (!s_beat && m_beat) owed_next = owed_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owed_reg <= '0;
        end else begin
            owed_reg <= owed_next;
        end
    end

    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> owed_reg != 2'd0)
        else $error("result beat with no request outstanding");

    a_bounded_backlog: assert property (@(posedge aclk) disable iff (!aresetn)
        owed_reg != 2'd3)
        else $error("more than two requests outstanding");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != dq_pkg::STAT_BAD)
        else $error("undefined status code");

    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != dq_pkg::STAT_OK) |-> m_tdata[7:0] == 8'd0)
        else $error("nonzero byte with failing status");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind byte_deque_with_index_read dq_checker u_dq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
